// ----- design/advr_pkg.sv -----
package advr_pkg;

    // Default size of the advertising data buffer, in bytes.
    localparam int ADVR_MAX_DATA_LEN = 31;

    // Report header: event type, address type, six address bytes, data length.
    localparam int HEADER_BYTES = 9;

    // Event and subevent codes that the parser acts on.
    localparam logic [7:0] LE_META_CODE      = 8'h3E;
    localparam logic [7:0] ADV_REPORT_SUBEVT = 8'h02;

    // Result item packing.
    localparam int IDX_W   = 5;
    localparam int TDATA_W = 96;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       cap_evt;
        logic       cap_atype;
        logic       cap_abyte;
        logic [2:0] abyte_sel;
        logic       cap_len;
        logic       store_data;
        logic       cap_rssi;
        logic       emit_start;
        logic       emit_rd;
        logic       emit_load;
    } t_advr_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic data_done;
        logic emit_last;
        logic out_free;
    } t_advr_stat;

endpackage

// ----- design/advr_dp.sv -----
module advr_dp #(
    parameter int MAX_DATA_LEN = advr_pkg::ADVR_MAX_DATA_LEN
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [7:0]              i_byte,
    input  advr_pkg::t_advr_cmd     i_cmd,
    input  logic                    i_m_tready,
    output advr_pkg::t_advr_stat    o_stat,
    output logic                    o_valid,
    output logic [7:0]              o_adv_kind,
    output logic [7:0]              o_addr_kind,
    output logic [47:0]             o_address,
    output logic [7:0]              o_rssi,
    output logic [7:0]              o_data_length,
    output logic [advr_pkg::IDX_W-1:0] o_data_index,
    output logic [7:0]              o_data_byte,
    output logic                    o_status,
    output logic                    o_last
);

    localparam int AW = (MAX_DATA_LEN > 1) ? $clog2(MAX_DATA_LEN) : 1;

    logic [7:0]    r_evt;
    logic [7:0]    r_atype;
    logic [47:0]   r_addr;
    logic [7:0]    r_len;
    logic [7:0]    r_rcvd;
    logic          r_oversize;
    logic [7:0]    r_rssi;
    logic [AW-1:0] r_k;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_mem [MAX_DATA_LEN];

    logic          r_out_valid;
    logic [7:0]    r_out_evt;
    logic [7:0]    r_out_atype;
    logic [47:0]   r_out_addr;
    logic [7:0]    r_out_rssi;
    logic [7:0]    r_out_len;
    logic [advr_pkg::IDX_W-1:0] r_out_idx;
    logic [7:0]    r_out_byte;
    logic          r_out_status;
    logic          r_out_last;

    logic          single;
    logic [7:0]    k_ext;

    // A report with no data or with oversized data gives one result only.
    assign single = r_oversize || (r_len == 8'd0);
    assign k_ext  = 8'(r_k);

    assign o_stat.data_done = (9'(r_rcvd) + 9'd1) >= 9'(r_len);
    assign o_stat.emit_last = single || ((k_ext + 8'd1) == r_len);
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    // Report header capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_evt) begin
            r_evt <= i_byte;
        end
        if (i_cmd.cap_atype) begin
            r_atype <= i_byte;
            r_addr  <= '0;
        end
        if (i_cmd.cap_abyte) begin
            r_addr[8*i_cmd.abyte_sel +: 8] <= i_byte;
        end
        if (i_cmd.cap_rssi) begin
            r_rssi <= i_byte;
        end
        if (i_cmd.cap_len) begin
            r_len      <= i_byte;
            r_rcvd     <= '0;
            r_oversize <= i_byte > 8'(MAX_DATA_LEN);
        end else if (i_cmd.store_data) begin
            r_rcvd <= r_rcvd + 8'd1;
        end
    end

    // Data buffer: bytes beyond the buffer are counted but not kept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_data && (r_rcvd < 8'(MAX_DATA_LEN))) begin
            r_mem[r_rcvd[AW-1:0]] <= i_byte;
        end
        if (i_cmd.emit_rd) begin
            r_rd_data <= r_mem[r_k];
        end
    end

    // Result index walks the buffer during delivery.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            r_k <= '0;
        end else if (i_cmd.emit_load) begin
            r_k <= r_k + AW'(1);
        end
    end

    // Output register: holds one result item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_evt    <= r_evt;
            r_out_atype  <= r_atype;
            r_out_addr   <= r_addr;
            r_out_rssi   <= r_rssi;
            r_out_len    <= r_len;
            r_out_idx    <= k_ext[advr_pkg::IDX_W-1:0];
            r_out_byte   <= single ? 8'd0 : r_rd_data;
            r_out_status <= r_oversize;
            r_out_last   <= o_stat.emit_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_adv_kind     = r_out_evt;
    assign o_addr_kind    = r_out_atype;
    assign o_address      = r_out_addr;
    assign o_rssi         = r_out_rssi;
    assign o_data_length  = r_out_len;
    assign o_data_index   = r_out_idx;
    assign o_data_byte    = r_out_byte;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

endmodule

// ----- design/advr_ctrl.sv -----
module advr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_first,
    input  advr_pkg::t_advr_stat i_stat,
    output advr_pkg::t_advr_cmd  o_cmd
);

    localparam logic [3:0] S_WAIT    = 4'd0;
    localparam logic [3:0] S_LEN     = 4'd1;
    localparam logic [3:0] S_SUBEVT  = 4'd2;
    localparam logic [3:0] S_COUNT   = 4'd3;
    localparam logic [3:0] S_HEADER  = 4'd4;
    localparam logic [3:0] S_DATA    = 4'd5;
    localparam logic [3:0] S_RSSI    = 4'd6;
    localparam logic [3:0] S_EMIT_RD = 4'd7;
    localparam logic [3:0] S_EMIT_LD = 4'd8;

    localparam logic [3:0] HDR_LAST = 4'(advr_pkg::HEADER_BYTES - 1);

    logic [3:0] r_state, n_state;
    logic [7:0] r_payload_left, n_payload_left;
    logic [7:0] r_reports_left, n_reports_left;
    logic [3:0] r_hdr_idx, n_hdr_idx;
    logic       r_scan_en;
    logic       accept;
    logic [7:0] reports_dec;

    assign o_ready     = (r_state != S_EMIT_RD) && (r_state != S_EMIT_LD);
    assign accept      = i_valid && o_ready;
    assign reports_dec = r_reports_left - 8'd1;

    // Scan enable register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_scan_en <= i_cfg_wdata;
        end
    end

    // Parser and delivery sequencing.
    always_comb begin
        n_state        = r_state;
        n_payload_left = r_payload_left;
        n_reports_left = r_reports_left;
        n_hdr_idx      = r_hdr_idx;
        o_cmd          = '0;
        o_cmd.abyte_sel = 3'(r_hdr_idx - 4'd2);

        if (r_state == S_EMIT_RD) begin
            o_cmd.emit_rd = 1'b1;
            n_state       = S_EMIT_LD;
        end else if (r_state == S_EMIT_LD) begin
            if (i_stat.out_free) begin
                o_cmd.emit_load = 1'b1;
                if (i_stat.emit_last) begin
                    n_reports_left = reports_dec;
                    n_hdr_idx      = '0;
                    n_state        = (reports_dec == 8'd0) ? S_WAIT : S_HEADER;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
        end else if (accept) begin
            if (i_first) begin
                n_state = (i_byte == advr_pkg::LE_META_CODE) ? S_LEN : S_WAIT;
            end else begin
                unique case (r_state)
                    S_WAIT: begin
                        n_state = S_WAIT;
                    end
                    S_LEN: begin
                        if (i_byte == 8'd0) begin
                            n_state = S_WAIT;
                        end else begin
                            n_payload_left = i_byte - 8'd1;
                            n_state        = S_SUBEVT;
                        end
                    end
                    S_SUBEVT: begin
                        n_state = (i_byte == advr_pkg::ADV_REPORT_SUBEVT) ? S_COUNT : S_WAIT;
                    end
                    S_COUNT, S_HEADER, S_DATA, S_RSSI: begin
                        if (r_payload_left == 8'd0) begin
                            // Payload used up: the report in progress is dropped.
                            n_state = S_WAIT;
                        end else begin
                            n_payload_left = r_payload_left - 8'd1;
                            unique case (r_state)
                                S_COUNT: begin
                                    n_reports_left = i_byte;
                                    n_hdr_idx      = '0;
                                    n_state        = (i_byte == 8'd0) ? S_WAIT : S_HEADER;
                                end
                                S_HEADER: begin
                                    n_hdr_idx = r_hdr_idx + 4'd1;
                                    priority if (r_hdr_idx == 4'd0) begin
                                        o_cmd.cap_evt = 1'b1;
                                    end else if (r_hdr_idx == 4'd1) begin
                                        o_cmd.cap_atype = 1'b1;
                                    end else if (r_hdr_idx < HDR_LAST) begin
                                        o_cmd.cap_abyte = 1'b1;
                                    end else begin
                                        o_cmd.cap_len = 1'b1;
                                        n_state = (i_byte == 8'd0) ? S_RSSI : S_DATA;
                                    end
                                end
                                S_DATA: begin
                                    o_cmd.store_data = 1'b1;
                                    if (i_stat.data_done) begin
                                        n_state = S_RSSI;
                                    end
                                end
                                default: begin
                                    // RSSI byte closes the report.
                                    o_cmd.cap_rssi = 1'b1;
                                    if (r_scan_en) begin
                                        o_cmd.emit_start = 1'b1;
                                        n_state          = S_EMIT_RD;
                                    end else begin
                                        n_reports_left = reports_dec;
                                        n_hdr_idx      = '0;
                                        n_state = (reports_dec == 8'd0) ? S_WAIT : S_HEADER;
                                    end
                                end
                            endcase
                        end
                    end
                    default: begin
                        n_state = S_WAIT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_WAIT;
            r_payload_left <= '0;
            r_reports_left <= '0;
            r_hdr_idx      <= '0;
        end else begin
            r_state        <= n_state;
            r_payload_left <= n_payload_left;
            r_reports_left <= n_reports_left;
            r_hdr_idx      <= n_hdr_idx;
        end
    end

endmodule

// ----- design/ble_adv_report_parser.sv -----
// Channel   Direction  Item                      Ports
// s         in         one HCI event byte        i_s_tvalid, o_s_tready, i_s_tdata, i_s_tuser
// m         out        one report data byte      o_m_tvalid, i_m_tready, o_m_tdata, o_m_tuser,
//                                                o_m_tlast
// cfg       in         scan enable               i_cfg_we, i_cfg_wdata
//
// The RSSI byte of a delivered report starts delivery: each result item takes a buffer read,
// then an output register load that waits until the output register is free, and a report
// holds the input until its R results are loaded, R being the data length, or one for a report
// with no data or oversized data. A result waits in the output register while i_m_tready is
// low; input is accepted again in the cycle after the final result of the report is loaded.
// Reset is synchronous and active low; it clears the parser, scan enable and output valid.
module ble_adv_report_parser #(
    parameter int MAX_DATA_LEN = advr_pkg::ADVR_MAX_DATA_LEN
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [7:0]                   i_s_tdata,   // [7:0] byte_value
    input  logic                         i_s_tuser,   // [0] first_byte
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [7:0] adv_kind, [15:8] addr_kind, [63:16] address, [71:64] rssi,
    // [79:72] data_length, [84:80] data_index, [92:85] data_byte, [95:93] zero
    output logic [advr_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                         o_m_tuser,   // [0] status
    output logic                         o_m_tlast
);

    advr_pkg::t_advr_cmd  cmd;
    advr_pkg::t_advr_stat stat;

    logic [7:0]                  adv_kind;
    logic [7:0]                  addr_kind;
    logic [47:0]                 address;
    logic [7:0]                  rssi;
    logic [7:0]                  data_length;
    logic [advr_pkg::IDX_W-1:0]  data_index;
    logic [7:0]                  data_byte;

    advr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_byte      (i_s_tdata),
        .i_first     (i_s_tuser),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    advr_dp #(
        .MAX_DATA_LEN (MAX_DATA_LEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte         (i_s_tdata),
        .i_cmd          (cmd),
        .i_m_tready     (i_m_tready),
        .o_stat         (stat),
        .o_valid        (o_m_tvalid),
        .o_adv_kind     (adv_kind),
        .o_addr_kind    (addr_kind),
        .o_address      (address),
        .o_rssi         (rssi),
        .o_data_length  (data_length),
        .o_data_index   (data_index),
        .o_data_byte    (data_byte),
        .o_status       (o_m_tuser),
        .o_last         (o_m_tlast)
    );

    // Pack the result fields, first field in the low bits.
    assign o_m_tdata = {3'b000, data_byte, data_index, data_length, rssi,
                        address, addr_kind, adv_kind};

endmodule
